@@ rtl/core/linear_blend_skinning_macros.svh @@
// Assertion macros used by the checker file.
`ifndef LINEAR_BLEND_SKINNING_MACROS_SVH
`define LINEAR_BLEND_SKINNING_MACROS_SVH

// Check a consequent in the cycle after the antecedent.
`define LBS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("linear_blend_skinning: next-cycle check failed");

// Check a consequent in the same cycle as the antecedent.
`define LBS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("linear_blend_skinning: same-cycle check failed");

`endif

@@ rtl/core/lbs_pkg.sv @@
// ----------------------------------------------------------------------------
// lbs_pkg
// Types, constants and rounding helpers for the skinning block.
// ----------------------------------------------------------------------------
package lbs_pkg;

    localparam int MAX_INFLUENCES = 64;
    localparam int FRAC_BITS      = 16;
    localparam int INF_W          = $clog2(MAX_INFLUENCES);
    localparam int ADDR_W         = INF_W + 4;
    localparam int TABLE_DEPTH    = MAX_INFLUENCES * 16;

    // Command codes
    localparam logic [1:0] CMD_LOAD_BIND = 2'd0;
    localparam logic [1:0] CMD_LOAD_POSE = 2'd1;
    localparam logic [1:0] CMD_FORM      = 2'd2;
    localparam logic [1:0] CMD_INFLUENCE = 2'd3;

    localparam logic signed [32:0] ONE_Q    = 33'sd1 <<< FRAC_BITS;
    localparam logic signed [67:0] HALF_Q   = 68'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [67:0] SAT_MAX  = 68'sd2147483647;
    localparam logic signed [67:0] SAT_MIN  = -68'sd2147483648;
    localparam logic signed [65:0] ACC_MAX  = 66'sd9223372036854775807;
    localparam logic signed [65:0] ACC_MIN  = -66'sd9223372036854775808;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FORM, ST_APPLY, ST_WEIGHT, ST_DRAIN, ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        OP_FORM, OP_APPLY, OP_WEIGHT
    } t_op;

    // Tag that travels with each product through the MAC pipeline
    typedef struct packed {
        t_op        op;
        logic       first;
        logic       last;
        logic [3:0] elem;
    } t_tag;

    // Round half up at FRAC_BITS, saturate to 32 bits; bit 32 flags a clip
    function automatic logic [32:0] round_sat(input logic signed [67:0] v);
        logic signed [67:0] r;
        logic [32:0]        res;
        r = (v + HALF_Q) >>> FRAC_BITS;
        if (r > SAT_MAX) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (r < SAT_MIN) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, r[31:0]};
        end
        return res;
    endfunction

    // Add a product into a 64-bit sum, clamping at the 64-bit limits
    function automatic logic signed [63:0] add_sat64(input logic signed [63:0] s,
                                                    input logic signed [65:0] p);
        logic signed [65:0] t;
        logic signed [63:0] res;
        t = {{2{s[63]}}, s} + p;
        if (t > ACC_MAX) begin
            res = 64'sh7FFF_FFFF_FFFF_FFFF;
        end else if (t < ACC_MIN) begin
            res = 64'sh8000_0000_0000_0000;
        end else begin
            res = t[63:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/core/lbs_ram.sv @@
// ----------------------------------------------------------------------------
// lbs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/linear_blend_skinning.sv @@
// ----------------------------------------------------------------------------
// linear_blend_skinning
// Fixed-point linear blend skinning around one shared 33x33 multiplier.
// ----------------------------------------------------------------------------
//  channel | valid        | ready        | payload
//  in      | i_in_valid   | o_in_ready   | command, indexes, element, point, weight
//  out     | o_out_valid  | i_out_ready  | new_x/y/z, saturated
//
// Load words leave ready high. A form word keeps ready low while its 64
// products pass through the single multiplier and the pipeline drains. An
// influence word keeps ready low for 12 transform products, a pipeline drain,
// 3 weight products, a second drain and, on the last influence, an emit step.
// The multiplier and the single read port of each matrix RAM serialise them.
// Reset clears control, sums and the clip flag; matrix RAMs are not cleared.
// A held result stalls the next point's emit step; loads are taken only in idle.
module linear_blend_skinning (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_command,
    input  logic [5:0]         i_influence_index,
    input  logic [3:0]         i_element_index,
    input  logic signed [31:0] i_element_value,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [16:0]        i_weight,
    input  logic               i_last_influence,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_new_x,
    output logic signed [31:0] o_new_y,
    output logic signed [31:0] o_new_z,
    output logic               o_saturated
);

    lbs_pkg::t_state r_state, n_state;
    lbs_pkg::t_op    r_drain_op, n_drain_op;
    logic [5:0]      r_cnt, n_cnt;
    logic [lbs_pkg::INF_W-1:0] r_base;
    logic signed [31:0] r_pt_x, r_pt_y, r_pt_z;
    logic [16:0]     r_w;
    logic            r_last;
    logic signed [31:0] r_t [3];
    logic            r_clip;
    logic signed [63:0] r_sum [3];

    // MAC pipeline
    logic            r_v1, r_v2, r_v3;
    lbs_pkg::t_tag   r_tag1, r_tag2, r_tag3;
    logic signed [65:0] r_prod;
    logic signed [67:0] r_acc;

    // Output register
    logic            r_out_valid;
    logic signed [31:0] r_new_x, r_new_y, r_new_z;
    logic            r_sat;

    logic            in_acc;
    logic            issue;
    lbs_pkg::t_tag   issue_tag;
    logic            do_emit;
    logic [lbs_pkg::ADDR_W-1:0] bind_raddr, pose_raddr, skin_raddr, skin_waddr;
    logic [31:0]     bind_q, pose_q, skin_q;
    logic signed [32:0] op_a, op_b;
    logic [32:0]     fin;
    logic [32:0]     em_x, em_y, em_z;

    assign o_in_ready = (r_state == lbs_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // Matrix stores
    lbs_ram #(.WIDTH(32), .DEPTH(lbs_pkg::TABLE_DEPTH)) u_bind (
        .i_clk   (i_clk),
        .i_we    (in_acc && i_command == lbs_pkg::CMD_LOAD_BIND),
        .i_waddr ({i_influence_index, i_element_index}),
        .i_wdata (i_element_value),
        .i_raddr (bind_raddr),
        .o_rdata (bind_q)
    );

    lbs_ram #(.WIDTH(32), .DEPTH(lbs_pkg::TABLE_DEPTH)) u_pose (
        .i_clk   (i_clk),
        .i_we    (in_acc && i_command == lbs_pkg::CMD_LOAD_POSE),
        .i_waddr ({i_influence_index, i_element_index}),
        .i_wdata (i_element_value),
        .i_raddr (pose_raddr),
        .o_rdata (pose_q)
    );

    assign fin        = lbs_pkg::round_sat(r_acc);
    assign skin_waddr = {r_base, r_tag3.elem};

    lbs_ram #(.WIDTH(32), .DEPTH(lbs_pkg::TABLE_DEPTH)) u_skin (
        .i_clk   (i_clk),
        .i_we    (r_v3 && r_tag3.op == lbs_pkg::OP_FORM),
        .i_waddr (skin_waddr),
        .i_wdata (fin[31:0]),
        .i_raddr (skin_raddr),
        .o_rdata (skin_q)
    );

    // Read addresses: form walks (row, col, k); apply walks (col, k)
    assign bind_raddr = {r_base, r_cnt[5:4], r_cnt[1:0]};
    assign pose_raddr = {r_base, r_cnt[1:0], r_cnt[3:2]};
    assign skin_raddr = {r_base, r_cnt[1:0], r_cnt[3:2]};

    assign em_x = lbs_pkg::round_sat({{4{r_sum[0][63]}}, r_sum[0]});
    assign em_y = lbs_pkg::round_sat({{4{r_sum[1][63]}}, r_sum[1]});
    assign em_z = lbs_pkg::round_sat({{4{r_sum[2][63]}}, r_sum[2]});

    // Sequencer: next state and issue tag
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_drain_op = r_drain_op;
        issue      = 1'b0;
        issue_tag  = '{op: lbs_pkg::OP_FORM, first: (r_cnt[1:0] == 2'd0),
                       last: (r_cnt[1:0] == 2'd3), elem: r_cnt[3:0]};
        do_emit    = 1'b0;
        unique case (r_state)
            lbs_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (in_acc && i_command == lbs_pkg::CMD_FORM) begin
                    n_state = lbs_pkg::ST_FORM;
                end else if (in_acc && i_command == lbs_pkg::CMD_INFLUENCE) begin
                    n_state = lbs_pkg::ST_APPLY;
                end
            end
            lbs_pkg::ST_FORM: begin
                issue          = 1'b1;
                issue_tag.elem = {r_cnt[5:4], r_cnt[3:2]};
                n_cnt          = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_state    = lbs_pkg::ST_DRAIN;
                    n_drain_op = lbs_pkg::OP_FORM;
                end
            end
            lbs_pkg::ST_APPLY: begin
                issue        = 1'b1;
                issue_tag.op = lbs_pkg::OP_APPLY;
                n_cnt        = r_cnt + 6'd1;
                if (r_cnt == 6'd11) begin
                    n_state    = lbs_pkg::ST_DRAIN;
                    n_drain_op = lbs_pkg::OP_APPLY;
                end
            end
            lbs_pkg::ST_WEIGHT: begin
                issue        = 1'b1;
                issue_tag.op = lbs_pkg::OP_WEIGHT;
                n_cnt        = r_cnt + 6'd1;
                if (r_cnt == 6'd2) begin
                    n_state    = lbs_pkg::ST_DRAIN;
                    n_drain_op = lbs_pkg::OP_WEIGHT;
                end
            end
            lbs_pkg::ST_DRAIN: begin
                n_cnt = '0;
                if (!r_v1 && !r_v2 && !r_v3) begin
                    if (r_drain_op == lbs_pkg::OP_APPLY) begin
                        n_state = lbs_pkg::ST_WEIGHT;
                    end else if (r_drain_op == lbs_pkg::OP_WEIGHT && r_last) begin
                        n_state = lbs_pkg::ST_EMIT;
                    end else begin
                        n_state = lbs_pkg::ST_IDLE;
                    end
                end
            end
            lbs_pkg::ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    do_emit = 1'b1;
                    n_state = lbs_pkg::ST_IDLE;
                end
            end
            default: n_state = lbs_pkg::ST_IDLE;
        endcase
    end

    // Operand select for the shared multiplier
    always_comb begin
        op_a = $signed({bind_q[31], bind_q});
        op_b = $signed({pose_q[31], pose_q});
        case (r_tag1.op)
            lbs_pkg::OP_APPLY: begin
                op_b = $signed({skin_q[31], skin_q});
                case (r_tag1.elem[1:0])
                    2'd0:    op_a = {r_pt_x[31], r_pt_x};
                    2'd1:    op_a = {r_pt_y[31], r_pt_y};
                    2'd2:    op_a = {r_pt_z[31], r_pt_z};
                    default: op_a = lbs_pkg::ONE_Q;
                endcase
            end
            lbs_pkg::OP_WEIGHT: begin
                op_a = {r_t[r_tag1.elem[1:0]][31], r_t[r_tag1.elem[1:0]]};
                op_b = $signed({16'd0, r_w});
            end
            default: ;
        endcase
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lbs_pkg::ST_IDLE;
            r_drain_op  <= lbs_pkg::OP_FORM;
            r_cnt       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_clip      <= 1'b0;
            r_sum[0]    <= '0;
            r_sum[1]    <= '0;
            r_sum[2]    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_drain_op <= n_drain_op;
            r_v1       <= issue;
            r_v2       <= r_v1;
            r_v3       <= r_v2 && r_tag2.last && r_tag2.op != lbs_pkg::OP_WEIGHT;
            // Collect clips from the transform
            if (r_v3 && r_tag3.op == lbs_pkg::OP_APPLY && fin[32]) begin
                r_clip <= 1'b1;
            end
            // Weighted accumulate
            if (r_v2 && r_tag2.op == lbs_pkg::OP_WEIGHT) begin
                r_sum[r_tag2.elem[1:0]] <= lbs_pkg::add_sat64(r_sum[r_tag2.elem[1:0]],
                                                               r_prod);
            end
            // Emit and clear the point
            if (do_emit) begin
                r_sum[0] <= '0;
                r_sum[1] <= '0;
                r_sum[2] <= '0;
                r_clip   <= 1'b0;
            end
            if (do_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_base <= i_influence_index;
            r_pt_x <= i_pos_x;
            r_pt_y <= i_pos_y;
            r_pt_z <= i_pos_z;
            r_w    <= i_weight;
            r_last <= i_last_influence;
        end
        r_tag1 <= issue_tag;
        r_tag2 <= r_tag1;
        r_prod <= op_a * op_b;
        if (r_v2) begin
            r_tag3 <= r_tag2;
            if (r_tag2.first) begin
                r_acc <= {{2{r_prod[65]}}, r_prod};
            end else begin
                r_acc <= r_acc + {{2{r_prod[65]}}, r_prod};
            end
        end
        if (r_v3 && r_tag3.op == lbs_pkg::OP_APPLY) begin
            r_t[r_tag3.elem[3:2]] <= fin[31:0];
        end
        if (do_emit) begin
            r_new_x <= em_x[31:0];
            r_new_y <= em_y[31:0];
            r_new_z <= em_z[31:0];
            r_sat   <= r_clip | em_x[32] | em_y[32] | em_z[32];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_new_x     = r_new_x;
    assign o_new_y     = r_new_y;
    assign o_new_z     = r_new_z;
    assign o_saturated = r_sat;

endmodule

@@ rtl/core/lbs_checker.sv @@
// ----------------------------------------------------------------------------
// lbs_checker
// Port-level checks on the skinning block, bound to the top level.
// ----------------------------------------------------------------------------
`include "linear_blend_skinning_macros.svh"

module lbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_command,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_new_x
);

    // Hold a stalled result word
    `LBS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_new_x))
    // Drop ready after a form or influence word
    `LBS_ASSERT_NEXT(a_busy, i_in_valid && o_in_ready && (i_command == lbs_pkg::CMD_FORM || i_command == lbs_pkg::CMD_INFLUENCE), !o_in_ready)
    // Keep ready after a load word
    `LBS_ASSERT_NEXT(a_load_fast, i_in_valid && o_in_ready && (i_command == lbs_pkg::CMD_LOAD_BIND || i_command == lbs_pkg::CMD_LOAD_POSE), o_in_ready)
    // A new result only comes out of a busy period
    `LBS_ASSERT_NOW(a_emit_busy, $rose(o_out_valid), !$past(o_in_ready))

endmodule

bind linear_blend_skinning lbs_checker u_lbs_checker (.*);
